// ----- hdl/qat_pkg.sv -----
// Shared types, character constants and scan modes of the quoted argument tokenizer.
package qat_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned COUNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic [1:0] CAUSE_WS    = 2'd0;
	localparam logic [1:0] CAUSE_COMMA = 2'd1;
	localparam logic [1:0] CAUSE_END   = 2'd2;

	typedef enum logic [2:0] {
		MODE_SKIP      = 3'd0,
		MODE_PLAIN     = 3'd1,
		MODE_SQ        = 3'd2,
		MODE_DQ        = 3'd3,
		MODE_PLAIN_ESC = 3'd4,
		MODE_DQ_ESC    = 3'd5
	} mode_t;

	typedef struct packed {
		logic       is_token_end;
		logic [7:0] out_byte;
		logic [1:0] stop_cause;
		logic       last_of_run;
	} word_t;

	typedef struct packed {
		mode_t      next_mode;
		logic [1:0] count;
		word_t      w0;
		word_t      w1;
	} dec_t;

endpackage

// ----- hdl/qat_decode.sv -----
// Combinational decode of one text byte into the next scan mode and up to two output words.
module qat_decode import qat_pkg::*; (
	input  mode_t      mode,
	input  logic [7:0] text_byte,
	input  logic       comma_splits,
	output dec_t       dec
);

	typedef struct packed {
		logic  valid;
		word_t w;
		mode_t mode;
	} act_t;

	function automatic word_t byte_word(input logic [7:0] b);
		word_t w;
		w = '0;
		w.out_byte = b;
		return w;
	endfunction

	function automatic word_t end_word(input logic [1:0] cause);
		word_t w;
		w = '0;
		w.is_token_end = 1'b1;
		w.stop_cause = cause;
		return w;
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
	endfunction

	function automatic act_t plain_act(input logic [7:0] b, input logic cs);
		act_t a;
		a = '0;
		a.mode = MODE_PLAIN;
		if (b == CH_NUL) begin
			a.valid = 1'b1;
			a.w = end_word(CAUSE_END);
			a.mode = MODE_SKIP;
		end else if (b == CH_SQUOTE) begin
			a.mode = MODE_SQ;
		end else if (b == CH_DQUOTE) begin
			a.mode = MODE_DQ;
		end else if (b == CH_BSLASH) begin
			a.mode = MODE_PLAIN_ESC;
		end else if (is_ws(b)) begin
			a.valid = 1'b1;
			a.w = end_word(CAUSE_WS);
			a.mode = MODE_SKIP;
		end else if ((b == CH_COMMA) && cs) begin
			a.valid = 1'b1;
			a.w = end_word(CAUSE_COMMA);
			a.mode = MODE_SKIP;
		end else begin
			a.valid = 1'b1;
			a.w = byte_word(b);
		end
		return a;
	endfunction

	function automatic act_t dq_act(input logic [7:0] b);
		act_t a;
		a = '0;
		a.mode = MODE_DQ;
		if (b == CH_NUL) begin
			a.valid = 1'b1;
			a.w = end_word(CAUSE_END);
			a.mode = MODE_SKIP;
		end else if (b == CH_DQUOTE) begin
			a.mode = MODE_PLAIN;
		end else if (b == CH_BSLASH) begin
			a.mode = MODE_DQ_ESC;
		end else begin
			a.valid = 1'b1;
			a.w = byte_word(b);
		end
		return a;
	endfunction

	act_t a;

	always_comb begin
		dec = '0;
		dec.next_mode = MODE_SKIP;
		a = '0;
		case (mode)
			MODE_PLAIN: begin
				a = plain_act(text_byte, comma_splits);
				dec.w0 = a.w;
				dec.count = {1'b0, a.valid};
				dec.next_mode = a.mode;
			end
			MODE_SQ: begin
				if (text_byte == CH_NUL) begin
					dec.w0 = end_word(CAUSE_END);
					dec.count = 2'd1;
					dec.next_mode = MODE_SKIP;
				end else if (text_byte == CH_SQUOTE) begin
					dec.next_mode = MODE_PLAIN;
				end else begin
					dec.w0 = byte_word(text_byte);
					dec.count = 2'd1;
					dec.next_mode = MODE_SQ;
				end
			end
			MODE_DQ: begin
				a = dq_act(text_byte);
				dec.w0 = a.w;
				dec.count = {1'b0, a.valid};
				dec.next_mode = a.mode;
			end
			MODE_PLAIN_ESC: begin
				if ((text_byte == CH_NUL) || (text_byte == CH_CR) || (text_byte == CH_LF)) begin
					a = plain_act(text_byte, comma_splits);
					dec.w0 = byte_word(CH_BSLASH);
					dec.w1 = a.w;
					dec.count = a.valid ? 2'd2 : 2'd1;
					dec.next_mode = a.mode;
				end else begin
					dec.w0 = byte_word(text_byte);
					dec.count = 2'd1;
					dec.next_mode = MODE_PLAIN;
				end
			end
			MODE_DQ_ESC: begin
				if (text_byte == CH_DQUOTE) begin
					dec.w0 = byte_word(CH_DQUOTE);
					dec.count = 2'd1;
					dec.next_mode = MODE_DQ;
				end else begin
					a = dq_act(text_byte);
					dec.w0 = byte_word(CH_BSLASH);
					dec.w1 = a.w;
					dec.count = a.valid ? 2'd2 : 2'd1;
					dec.next_mode = a.mode;
				end
			end
			default: begin
				if ((text_byte != CH_SPACE) && (text_byte != CH_TAB)) begin
					a = plain_act(text_byte, comma_splits);
					dec.w0 = a.w;
					dec.count = {1'b0, a.valid};
					dec.next_mode = a.mode;
				end
			end
		endcase
		if (dec.count == 2'd1) begin
			dec.w0.last_of_run = 1'b1;
		end
		if (dec.count == 2'd2) begin
			dec.w1.last_of_run = 1'b1;
		end
	end

endmodule

// ----- hdl/qat_outq.sv -----
// Short shifting queue of output words that takes up to two words and gives one per cycle when popped.
module qat_outq import qat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_count,
	input  word_t      push_w0,
	input  word_t      push_w1,
	input  logic       pop,
	output logic       room,
	output logic       head_valid,
	output word_t      head
);

	word_t              slot_q [QUEUE_DEPTH];
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] base;
	logic [COUNT_W-1:0] count_d;

	assign head_valid = (count_q != '0);
	assign head = slot_q[0];
	assign room = (count_q <= COUNT_W'(QUEUE_DEPTH - 2));
	assign base = count_q - COUNT_W'(pop);
	assign count_d = base + COUNT_W'(push_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
			if ((push_count == 2'd2) && (COUNT_W'(i) == base + COUNT_W'(1))) begin
				slot_q[i] <= push_w1;
			end else if ((push_count != 2'd0) && (COUNT_W'(i) == base)) begin
				slot_q[i] <= push_w0;
			end else if (pop) begin
				slot_q[i] <= slot_q[i + 1];
			end
		end
		if ((push_count == 2'd2) && (COUNT_W'(QUEUE_DEPTH - 1) == base + COUNT_W'(1))) begin
			slot_q[QUEUE_DEPTH - 1] <= push_w1;
		end else if ((push_count != 2'd0) && (COUNT_W'(QUEUE_DEPTH - 1) == base)) begin
			slot_q[QUEUE_DEPTH - 1] <= push_w0;
		end
	end

endmodule

// ----- hdl/quoted_argument_tokenizer_unit.sv -----
// Top level of the quoted argument tokenizer: mode register, byte decode and output queue.
//
//   channel   direction   handshake              word
//   input     in          in_valid / in_stall    text_byte
//   output    out         out_valid / out_stall  is_token_end, out_byte, stop_cause, last_of_run
//   config    in          cfg_wr_en              comma_splits
//
// A text byte is decoded in the cycle it is accepted and its words are registered in the
// output queue; one byte is accepted per cycle while in_stall is low.
// A byte that yields two words is absorbed by the four-word queue, which gives one word at a time.
// in_stall rises while the queue holds three or more words; out_stall only holds the queue.
// Reset puts the scanner in the blank-skipping mode, empties the queue and sets comma_splits.
module quoted_argument_tokenizer_unit import qat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_comma_splits,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       is_token_end,
	output logic [7:0] out_byte,
	output logic [1:0] stop_cause,
	output logic       last_of_run
);

	mode_t      mode_q;
	logic       comma_splits_q;
	dec_t       dec;
	logic       in_take;
	logic       room;
	word_t      head;
	logic [1:0] push_count;

	assign in_stall = !room;
	assign in_take = in_valid && room;
	assign push_count = in_take ? dec.count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SKIP;
			comma_splits_q <= 1'b1;
		end else begin
			if (in_take) begin
				mode_q <= dec.next_mode;
			end
			if (cfg_wr_en) begin
				comma_splits_q <= cfg_comma_splits;
			end
		end
	end

	qat_decode u_decode (
		.mode         (mode_q),
		.text_byte    (text_byte),
		.comma_splits (comma_splits_q),
		.dec          (dec)
	);

	qat_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push_w0    (dec.w0),
		.push_w1    (dec.w1),
		.pop        (out_valid && !out_stall),
		.room       (room),
		.head_valid (out_valid),
		.head       (head)
	);

	assign is_token_end = head.is_token_end;
	assign out_byte = head.out_byte;
	assign stop_cause = head.stop_cause;
	assign last_of_run = head.last_of_run;

endmodule

// ----- hdl/qat_checker.sv -----
// Port checker of the quoted argument tokenizer and its bind to the top level.
module qat_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       is_token_end,
	input logic [7:0] out_byte,
	input logic [1:0] stop_cause,
	input logic       last_of_run
);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(is_token_end)
			&& $stable(stop_cause) && $stable(last_of_run))
		else $error("Stalled output word changed.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_token_end |-> (out_byte == 8'd0) && last_of_run)
		else $error("Token end word carries a byte or is not last of its run.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_token_end |-> stop_cause == 2'd0)
		else $error("Argument byte word carries a stop cause.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("Second word of a run is missing.");

endmodule

bind quoted_argument_tokenizer_unit qat_checker u_qat_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.is_token_end (is_token_end),
	.out_byte     (out_byte),
	.stop_cause   (stop_cause),
	.last_of_run  (last_of_run)
);
